@@ rtl/lgrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgrs_pkg
// Shared types and constants of the Life row stencil core.
// ----------------------------------------------------------------------------
`default_nettype none

package lgrs_pkg;

  localparam int MAX_COLS   = 64;
  localparam int LANES      = 8;
  localparam int LANE_W     = MAX_COLS / LANES;
  localparam int WIN_W      = LANE_W + 2;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int GEN_W      = 17;

  localparam logic [GEN_W-1:0] GEN_SAT = GEN_W'(65536);

  // register index, taken from paddr[2]
  localparam logic REG_NUM_COLS  = 1'b0;
  localparam logic REG_GEN_LIMIT = 1'b1;

  typedef struct packed {
    logic [MAX_COLS-1:0] row_bits;
    logic                last_row;
  } in_t;

  typedef struct packed {
    logic [MAX_COLS-1:0] next_row;
    logic                frame_end;
    logic                all_dead;
    logic                limit_reached;
  } out_t;

  // words handed to the output queue in one cycle
  typedef struct packed {
    logic [1:0] num;
    out_t       d0;
    out_t       d1;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/lgrs_lane.sv @@
// ----------------------------------------------------------------------------
// lgrs_lane
// B3/S23 rule for one slice of LANE_W columns from three row windows.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_lane
  import lgrs_pkg::*;
(
  input  wire logic [WIN_W-1:0]  up_win,
  input  wire logic [WIN_W-1:0]  mid_win,
  input  wire logic [WIN_W-1:0]  low_win,
  input  wire logic [LANE_W-1:0] inner,
  output logic      [LANE_W-1:0] cells
);

  always_comb begin
    logic [3:0] k;
    for (int c = 0; c < LANE_W; c++) begin
      // window bit c+1 is this lane's cell c
      k = 4'(up_win[c]) + 4'(up_win[c+1]) + 4'(up_win[c+2])
        + 4'(mid_win[c]) + 4'(mid_win[c+2])
        + 4'(low_win[c]) + 4'(low_win[c+1]) + 4'(low_win[c+2]);
      cells[c] = inner[c] & ((k == 4'd3) | ((k == 4'd2) & mid_win[c+1]));
    end
  end

endmodule

`default_nettype wire

@@ rtl/lgrs_ofifo.sv @@
// ----------------------------------------------------------------------------
// lgrs_ofifo
// Small result queue: takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module lgrs_ofifo
  import lgrs_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output logic       room,
  output logic       res_valid,
  input  wire logic  res_ready,
  output out_t       res_word
);

  out_t             mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             pop;

  assign pop       = res_valid & res_ready;
  assign res_valid = (count != '0);
  assign res_word  = mem[rd_ptr];
  // room for the two words that a last row may bring
  assign room      = (count <= CNT_W'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= push.d0;
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push.num) - CNT_W'(pop);
    end
  end

endmodule

`default_nettype wire

@@ rtl/life_generation_row_stencil_core.sv @@
// Life generation row stencil core (B3/S23).
// Throughput: one row word per cycle while row_ready is high; a last row
// yields two result words (one if first in its frame); words queue on accept.
// Eight lanes of LANE_W columns cover the 64-bit row in the accept cycle.
// Reset (rst, synchronous): row history, counters and queue clear;
// num_cols returns to 64 and gen_limit to 1000.
// ----------------------------------------------------------------------------
// life_generation_row_stencil_core
// Streams rows in, emits the next generation one row behind, plus frame end.
// ----------------------------------------------------------------------------
`default_nettype none

module life_generation_row_stencil_core
  import lgrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        row_valid,
  output logic             row_ready,
  input  wire in_t         row_word,
  output logic             res_valid,
  input  wire logic        res_ready,
  output out_t             res_word
);

  logic [6:0]          num_cols;
  logic [15:0]         gen_limit;
  logic [MAX_COLS-1:0] upper_row;
  logic [MAX_COLS-1:0] middle_row;
  logic [1:0]          rows_seen;
  logic                any_alive;
  logic [GEN_W-1:0]    generation_count;

  logic                acc;
  logic                wr_en;
  logic [6:0]          eff_cols;
  logic [MAX_COLS-1:0] wmask;
  logic [MAX_COLS-1:0] inner;
  logic [MAX_COLS-1:0] cur;
  logic [MAX_COLS+1:0] up_pad;
  logic [MAX_COLS+1:0] mid_pad;
  logic [MAX_COLS+1:0] low_pad;
  logic [MAX_COLS-1:0] nx;
  logic                nx_any;
  logic [GEN_W-1:0]    gen_next;
  out_t                row_res;
  out_t                end_res;
  push_t               push;
  logic                room;

  // config port
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cols  <= 7'd64;
      gen_limit <= 16'd1000;
    end else if (wr_en) begin
      case (paddr[2])
        REG_NUM_COLS:  num_cols  <= pwdata[6:0];
        REG_GEN_LIMIT: gen_limit <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_COLS:  prdata = {25'd0, num_cols};
      REG_GEN_LIMIT: prdata = {16'd0, gen_limit};
      default:       prdata = '0;
    endcase
  end

  // width in use, held to MAX_COLS
  assign eff_cols = (num_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : num_cols;

  // column masks: in use below the width, interior excludes both edges
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      wmask[c] = (eff_cols > 7'(c));
      inner[c] = (c != 0) && (eff_cols > 7'(c + 1));
    end
  end

  assign acc     = row_valid & row_ready;
  assign cur     = row_word.row_bits & wmask;
  assign up_pad  = {1'b0, upper_row, 1'b0};
  assign mid_pad = {1'b0, middle_row, 1'b0};
  assign low_pad = {1'b0, cur, 1'b0};

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    lgrs_lane u_lane (
      .up_win  (up_pad[l*LANE_W +: WIN_W]),
      .mid_win (mid_pad[l*LANE_W +: WIN_W]),
      .low_win (low_pad[l*LANE_W +: WIN_W]),
      .inner   (inner[l*LANE_W +: LANE_W]),
      .cells   (nx[l*LANE_W +: LANE_W])
    );
  end

  // merge: lanes concatenate into nx, alive flag folds over all of them
  assign nx_any   = |nx;
  assign gen_next = (generation_count < GEN_SAT) ? generation_count + GEN_W'(1)
                                                 : generation_count;

  always_comb begin
    row_res          = '0;
    row_res.next_row = (rows_seen == 2'd1) ? '0 : nx;

    end_res               = '0;
    end_res.frame_end     = 1'b1;
    end_res.all_dead      = ~(any_alive | ((rows_seen == 2'd2) & nx_any));
    end_res.limit_reached = (gen_next > {1'b0, gen_limit});

    push = '0;
    if (rows_seen != 2'd0) begin
      push.d0  = row_res;
      push.d1  = end_res;
      push.num = row_word.last_row ? 2'd2 : 2'd1;
    end else begin
      push.d0  = end_res;
      push.d1  = end_res;
      push.num = row_word.last_row ? 2'd1 : 2'd0;
    end
    if (!acc) begin
      push.num = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_row        <= '0;
      middle_row       <= '0;
      rows_seen        <= '0;
      any_alive        <= 1'b0;
      generation_count <= '0;
    end else if (acc) begin
      if (row_word.last_row) begin
        upper_row        <= '0;
        middle_row       <= '0;
        rows_seen        <= '0;
        any_alive        <= 1'b0;
        generation_count <= gen_next;
      end else begin
        upper_row  <= middle_row;
        middle_row <= cur;
        if (rows_seen != 2'd2) begin
          rows_seen <= rows_seen + 2'd1;
        end
        if ((rows_seen == 2'd2) && nx_any) begin
          any_alive <= 1'b1;
        end
      end
    end
  end

  assign row_ready = room;

  lgrs_ofifo u_ofifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    acc && row_word.last_row |=> res_valid)
    else $error("last row accepted but no result queued");

  a_two_only_on_last: assert property (@(posedge clk) disable iff (rst)
    push.num == 2'd2 |-> acc && row_word.last_row && rows_seen != 2'd0)
    else $error("double push without a last row");

  a_gen_saturates: assert property (@(posedge clk) disable iff (rst)
    generation_count <= GEN_SAT)
    else $error("generation count past saturation");

  a_history_clears: assert property (@(posedge clk) disable iff (rst)
    acc && row_word.last_row |=> rows_seen == 2'd0 && !any_alive)
    else $error("frame state not cleared at frame end");

endmodule

`default_nettype wire

@@ sim/life_generation_row_stencil_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// life_generation_row_stencil_core_test
// Streams Life frames row by row through the core and checks every result
// word against a B3/S23 row model kept in the bench, across several column
// widths and generation limits, with random idling on both channels.
// ----------------------------------------------------------------------------

module life_generation_row_stencil_core_test;
  import lgrs_pkg::*;

  localparam int NUM_PHASES = 12;
  localparam int PHASE_ROWS = 146;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        row_valid;
  logic        row_ready;
  in_t         row_word;
  logic        res_valid;
  logic        res_ready;
  out_t        res_word;

  bit idle_on;

  life_generation_row_stencil_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .row_valid (row_valid),
    .row_ready (row_ready),
    .row_word  (row_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  // Row model: keeps its own copy of the registers and the row history.
  class life_scoreboard;
    logic [6:0]  num_cols;
    logic [15:0] gen_limit;
    logic [63:0] upper_row;
    logic [63:0] middle_row;
    int          rows_seen;
    bit          any_alive;
    int unsigned gen_count;
    out_t        due_words[$];
    int          errors;
    int          rows_in;
    int          frames;
    int          words_checked;

    function new();
      num_cols   = 7'd64;
      gen_limit  = 16'd1000;
      upper_row  = '0;
      middle_row = '0;
      rows_seen  = 0;
      any_alive  = 0;
      gen_count  = 0;
      errors     = 0;
      rows_in    = 0;
      frames     = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == REG_NUM_COLS) num_cols = data[6:0];
      else gen_limit = data[15:0];
    endfunction

    function int bit_at(logic [63:0] row, int c);
      if (c < 0 || c > 63) return 0;
      return int'(row[c]);
    endfunction

    function logic [63:0] life_rule(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                    logic [63:0] inner);
      logic [63:0] res;
      int k;
      int c;
      res = '0;
      for (c = 0; c < 64; c++) begin
        if (inner[c]) begin
          k = bit_at(a, c-1) + bit_at(a, c) + bit_at(a, c+1)
            + bit_at(b, c-1) + bit_at(b, c+1)
            + bit_at(d, c-1) + bit_at(d, c) + bit_at(d, c+1);
          if (k == 3 || (k == 2 && b[c])) res[c] = 1'b1;
        end
      end
      return res;
    endfunction

    function void take_row(in_t w);
      int unsigned n;
      logic [63:0] wmask;
      logic [63:0] inner;
      logic [63:0] cur;
      logic [63:0] nx;
      out_t o;
      n     = (num_cols > 7'd64) ? 64 : num_cols;
      wmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      inner = (n < 3) ? 64'd0 : (wmask & ~64'd1 & ~(64'd1 << (n - 1)));
      cur   = w.row_bits & wmask;
      rows_in++;
      if (rows_seen == 1) begin
        // row above is the top border
        o = '0;
        due_words.insert(due_words.size(), o);
      end else if (rows_seen >= 2) begin
        nx = life_rule(upper_row, middle_row, cur, inner);
        if (nx != 0) any_alive = 1;
        o = '0;
        o.next_row = nx;
        due_words.insert(due_words.size(), o);
      end
      if (w.last_row) begin
        if (gen_count < 65536) gen_count++;
        o = '0;
        o.frame_end     = 1'b1;
        o.all_dead      = !any_alive;
        o.limit_reached = (gen_count > gen_limit);
        due_words.insert(due_words.size(), o);
        upper_row  = '0;
        middle_row = '0;
        rows_seen  = 0;
        any_alive  = 0;
        frames++;
      end else begin
        upper_row  = middle_row;
        middle_row = cur;
        if (rows_seen < 2) rows_seen++;
      end
    endfunction

    function void check_word(out_t got);
      out_t exp;
      if (due_words.size() == 0) begin
        $error("result word with none due: next_row %h frame_end %b", got.next_row,
               got.frame_end);
        errors++;
        return;
      end
      exp = due_words.pop_front();
      words_checked++;
      if (got.next_row !== exp.next_row) begin
        $error("next_row: expected %h, got %h", exp.next_row, got.next_row);
        errors++;
      end
      if (got.frame_end !== exp.frame_end) begin
        $error("frame_end: expected %b, got %b", exp.frame_end, got.frame_end);
        errors++;
      end
      if (got.all_dead !== exp.all_dead) begin
        $error("all_dead: expected %b, got %b", exp.all_dead, got.all_dead);
        errors++;
      end
      if (got.limit_reached !== exp.limit_reached) begin
        $error("limit_reached: expected %b, got %b", exp.limit_reached, got.limit_reached);
        errors++;
      end
    endfunction
  endclass

  life_scoreboard sb;
  int settings_used;
  int frame_left;
  logic [63:0] prev_row;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_word(res_word);
  end

  // result side: random stall bursts while idle_on is set
  initial begin
    res_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      res_ready <= 1'b1;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
  end

  task automatic send_row(in_t w);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      row_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    row_valid <= 1'b1;
    row_word  <= w;
    @(posedge clk);
    while (!row_ready) @(posedge clk);
    sb.take_row(w);
  endtask

  // lower valid and let every due word come out
  task automatic drain_results();
    row_valid <= 1'b0;
    while (sb.due_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic idx, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.write_reg(idx, data);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(logic idx, logic [31:0] exp);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== exp) begin
      $error("prdata reg %0d: expected %h, got %h", idx, exp, prdata);
      sb.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // upper pwdata bits may carry junk; only the register's own bits count
  task automatic set_config(logic [6:0] cols, logic [15:0] limit);
    drain_results();
    apb_write(REG_NUM_COLS, {$urandom_range(0, 1) ? 25'($urandom) : 25'd0, cols});
    apb_write(REG_GEN_LIMIT, {$urandom_range(0, 1) ? 16'($urandom) : 16'd0, limit});
    apb_read_check(REG_NUM_COLS, {25'd0, cols});
    apb_read_check(REG_GEN_LIMIT, {16'd0, limit});
    settings_used++;
  endtask

  function automatic logic [63:0] rand_row();
    logic [63:0] a;
    logic [63:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return a;
      5: return a & b & {$urandom, $urandom};
      6: return a | b;
      7: return 64'd1 << $urandom_range(0, 63);
      8: return prev_row;
      default: return a & b;
    endcase
  endfunction

  function automatic in_t next_random_row();
    in_t w;
    int r;
    if (frame_left == 0) begin
      r = $urandom_range(0, 9);
      frame_left = (r == 0) ? 1 : (r == 1) ? 2 : $urandom_range(3, 20);
    end
    w.row_bits = rand_row();
    w.last_row = (frame_left == 1);
    prev_row   = w.row_bits;
    frame_left--;
    return w;
  endfunction

  function automatic in_t mk_row(logic [63:0] bits, logic last);
    in_t w;
    w.row_bits = bits;
    w.last_row = last;
    return w;
  endfunction

  initial begin
    in_t directed[$];
    in_t w;
    logic [6:0]  cols;
    logic [15:0] limit;
    sb            = new();
    settings_used = 1;
    frame_left    = 0;
    prev_row      = '0;
    idle_on       = 1'b1;
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    row_valid <= 1'b0;
    row_word  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-row frame: only the dead frame-end word
    directed.insert(directed.size(), mk_row('1, 1'b1));
    // blinker
    directed.insert(directed.size(), mk_row(64'h0, 1'b0));
    directed.insert(directed.size(), mk_row(64'h38, 1'b0));
    directed.insert(directed.size(), mk_row(64'h0, 1'b0));
    directed.insert(directed.size(), mk_row(64'h0, 1'b1));
    // overcrowded solid block
    repeat (3) directed.insert(directed.size(), mk_row('1, 1'b0));
    directed.insert(directed.size(), mk_row('1, 1'b1));
    // life on the border columns must stay dead
    directed.insert(directed.size(), mk_row(64'h8000_0000_0000_0001, 1'b0));
    directed.insert(directed.size(), mk_row(64'hC000_0000_0000_0003, 1'b0));
    directed.insert(directed.size(), mk_row(64'h8000_0000_0000_0001, 1'b0));
    directed.insert(directed.size(), mk_row(64'h5555_5555_5555_5555, 1'b1));
    // two-row frame
    directed.insert(directed.size(), mk_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
    directed.insert(directed.size(), mk_row(64'h5555_5555_5555_5555, 1'b1));
    // glider
    directed.insert(directed.size(), mk_row(64'h0, 1'b0));
    directed.insert(directed.size(), mk_row(64'h4, 1'b0));
    directed.insert(directed.size(), mk_row(64'h8, 1'b0));
    directed.insert(directed.size(), mk_row(64'hE, 1'b0));
    directed.insert(directed.size(), mk_row(64'h0, 1'b1));
    foreach (directed[i]) send_row(directed[i]);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:  begin cols = 7'd3;   limit = 16'd0;                 end
        1:  begin cols = 7'd64;  limit = 16'hFFFF;              end
        2:  begin cols = 7'd127; limit = 16'(sb.gen_count + 3); end
        3:  begin cols = 7'd0;   limit = 16'd1000;              end
        4:  begin cols = 7'd1;   limit = 16'($urandom);         end
        5:  begin cols = 7'd2;   limit = 16'(sb.gen_count + 8); end
        6:  begin cols = 7'd65;  limit = 16'(sb.gen_count + 5); end
        7:  begin cols = 7'($urandom_range(3, 64)); limit = 16'($urandom); end
        8:  begin cols = 7'd4;   limit = 16'(sb.gen_count);     end
        9:  begin cols = 7'($urandom_range(3, 64)); limit = 16'(sb.gen_count + 12); end
        10: begin cols = 7'd63;  limit = 16'(sb.gen_count + 10); end
        default: begin cols = 7'd64; limit = 16'd1000;         end
      endcase
      // frames run on across the register writes
      set_config(cols, limit);
      idle_on = (p != NUM_PHASES - 1) && ($urandom_range(0, 4) != 0);
      for (int i = 0; i < PHASE_ROWS; i++) begin
        if (p == 4 && i == PHASE_ROWS / 2) drain_results();
        w = next_random_row();
        send_row(w);
      end
    end
    drain_results();

    $display("Streamed %0d rows in %0d frames under %0d register settings;",
             sb.rows_in, sb.frames, settings_used);
    $display("checked %0d result words, widths 0 to 127 and limits 0 to 65535.",
             sb.words_checked);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // pready has no wait states; checked once, after reset
  initial begin
    @(posedge clk);
    while (rst) @(posedge clk);
    if (pready !== 1'b1) begin
      $error("pready: expected 1, got %b", pready);
      sb.errors++;
    end
  end

endmodule

@@ filelist.f @@
rtl/lgrs_pkg.sv
rtl/lgrs_lane.sv
rtl/lgrs_ofifo.sv
rtl/life_generation_row_stencil_core.sv
sim/life_generation_row_stencil_core_test.sv
